>>> hw/rtl/adx_pkg.sv
// Shared types and constants for the ADX ADPCM block decoder.
package adx_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int IDX_W      = 9;
   localparam int HIST_W     = 2 * SAMPLE_W;
   localparam int FRAC_BITS  = 12;
   localparam int CHN_CNT_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [7:0] MIN_BLOCK_BYTES   = 8'd3;
   localparam logic [7:0] RESET_BLOCK_BYTES = 8'd18;
   localparam logic [3:0] RESET_CHANNELS    = 4'd1;
   localparam logic [3:0] NIB_MASK          = 4'hF;

   localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_FIRST    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_SECOND   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_BYTES   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS_USED = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_SAMPLES = 3'd4;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } hist_cmd_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
   } mac_ctl_type;

endpackage

>>> hw/rtl/adx_if.sv
// Request and response channel interfaces.
interface adx_req_if import adx_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       stream_end;

   modport source (output valid, data_byte, stream_end, input ready);
   modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface adx_rsp_if import adx_pkg::*; ();
   logic             valid;
   logic             ready;
   sample_type       sample;
   logic [2:0]       channel;
   logic [IDX_W-1:0] sample_index;
   logic             last_of_run;
   logic             final_sample;

   modport source (output valid, sample, channel, sample_index, last_of_run, final_sample,
                   input ready);
   modport sink   (input valid, sample, channel, sample_index, last_of_run, final_sample,
                   output ready);
endinterface

>>> hw/rtl/adx_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module adx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/adx_hist.sv
// Per-channel history store: RAM plus valid bits, unwritten entries read as zero.
module adx_hist import adx_pkg::*; #(
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  hist_cmd_type      cmd,
   input  logic [AW-1:0]     addr,
   input  logic [HIST_W-1:0] wr_data,
   output logic [HIST_W-1:0] rd_data
);

   logic [DEPTH-1:0]  valid_ff, valid_in;
   logic              hit_ff, hit_in;
   logic [HIST_W-1:0] ram_q;

   adx_ram #(.WIDTH(HIST_W), .DEPTH(DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_en),
      .wr_addr (addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr),
      .rd_data (ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear) begin
         valid_in = '0;
      end else if (cmd.wr_en) begin
         valid_in[addr] = 1'b1;
      end
      hit_in = cmd.rd_en ? valid_ff[addr] : hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   assign rd_data = hit_ff ? ram_q : '0;

endmodule

>>> hw/rtl/adx_mac.sv
// Prediction datapath: registered products, then a registered sum/shift/saturate stage.
module adx_mac import adx_pkg::*; (
   input  logic        clock,
   input  mac_ctl_type ctl,
   input  sample_type  coef_first,
   input  sample_type  coef_second,
   input  sample_type  hist_newest,
   input  sample_type  hist_older,
   input  logic [15:0] scale,
   input  logic [3:0]  nibble,
   output sample_type  sample
);

   localparam int PD_W  = 21;
   localparam int PP_W  = 32;
   localparam int ACC_W = 36;

   logic signed [PD_W-1:0]  pd_ff, pd_in;
   logic signed [PP_W-1:0]  p1_ff, p1_in;
   logic signed [PP_W-1:0]  p2_ff, p2_in;
   sample_type              sample_ff, sample_in;
   logic signed [3:0]       delta;
   logic signed [16:0]      scale_s;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] shifted;

   always_comb begin
      delta   = $signed(nibble & NIB_MASK);
      scale_s = $signed({1'b0, scale});
      pd_in   = PD_W'(delta) * PD_W'(scale_s);
      p1_in   = PP_W'(coef_first) * PP_W'(hist_newest);
      p2_in   = PP_W'(coef_second) * PP_W'(hist_older);

      acc     = (ACC_W'(pd_ff) <<< FRAC_BITS) + ACC_W'(p1_ff) + ACC_W'(p2_ff);
      shifted = acc >>> FRAC_BITS;       // floor
      if (shifted > ACC_W'(SAT_MAX)) begin
         sample_in = SAT_MAX;
      end else if (shifted < ACC_W'(SAT_MIN)) begin
         sample_in = SAT_MIN;
      end else begin
         sample_in = shifted[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         pd_ff <= pd_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (ctl.sum_en) begin
         sample_ff <= sample_in;
      end
   end

   assign sample = sample_ff;

endmodule

>>> hw/rtl/adx_adpcm_block_decoder_core.sv
// Top level of the ADX 4-bit ADPCM block decoder.
//
// Usage:
//  - req carries one byte of the block area per request (data_byte) and a
//    stream_end flag; after that byte the parse position, scale, sample count
//    and per-channel histories return to their start values.
//  - rsp carries decoded samples with channel, index within block, last-of-byte
//    and end-of-stream flags. A data byte yields zero, one or two samples.
//  - csr_* is a write-only register port (coefficients, block size, channel
//    count, total samples); write only while the decoder is idle.
// Sequence:
//  - Scale bytes and bytes past the sample count leave the decoder idle and ready.
//  - A data byte runs a history read, then multiply, accumulate/saturate and
//    emit for each nibble, then the history write-back. The nibble chain
//    through the shared multiply-accumulate and the single history RAM keeps
//    these steps in sequence.
//  - The first sample reaches rsp through the LOAD, MUL, SUM and EMIT states.
// Reset: synchronous, active high; control and configuration registers return
//    to defaults and all history entries read as zero (valid bits, no clearing pass).
// Stall: a held rsp keeps its sample; the decoder waits in the emit step and
//    takes no new request until the byte's last sample has entered the rsp
//    register and the history write-back step has run.
module adx_adpcm_block_decoder_core import adx_pkg::*; #(
   parameter int MAX_CHANNELS = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   adx_req_if.sink               req,
   adx_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam logic [CHN_CNT_W-1:0] MAX_CHN = CHN_CNT_W'(MAX_CHANNELS);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_MUL, S_SUM, S_EMIT, S_WRITE
   } state_type;

   // per-byte work latched at request time
   typedef struct packed {
      logic [CH_W-1:0]  ch;
      logic [15:0]      scale;
      logic [7:0]       data;
      logic [IDX_W-1:0] base;
      logic             prod1;
      logic             fin0;
      logic             fin1;
      logic             restart;
   } op_type;

   // configuration
   sample_type  coef1_ff, coef1_in;
   sample_type  coef2_ff, coef2_in;
   logic [7:0]  bb_cfg_ff, bb_cfg_in;
   logic [3:0]  chn_cfg_ff, chn_cfg_in;
   logic [31:0] total_ff, total_in;

   // parse state
   logic [CH_W-1:0]  cc_ff, cc_in;
   logic [7:0]       bib_ff, bib_in;
   logic [15:0]      scale_ff, scale_in;
   logic [31:0]      sl_ff, sl_in;
   logic [IDX_W-1:0] fs_ff, fs_in;

   // sequencer
   state_type  state_ff, state_in;
   op_type     op_ff, op_in;
   logic       nib_ff, nib_in;
   sample_type h1_ff, h1_in;
   sample_type h2_ff, h2_in;

   // response register
   logic             rsp_valid_ff, rsp_valid_in;
   sample_type       rsp_sample_ff, rsp_sample_in;
   logic [2:0]       rsp_ch_ff, rsp_ch_in;
   logic [IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_fin_ff, rsp_fin_in;

   // datapath links
   hist_cmd_type      hist_cmd;
   logic [CH_W-1:0]   hist_addr;
   logic [HIST_W-1:0] hist_rdata;
   mac_ctl_type       mac_ctl;
   sample_type        mac_sample;

   // request decode
   logic                 accept;
   logic [7:0]           bb;
   logic [CHN_CNT_W-1:0] chn;
   logic [IDX_W-1:0]     spb;
   logic [IDX_W-1:0]     fs_next;
   logic [IDX_W-1:0]     idx0;
   logic [IDX_W-1:0]     idx1;
   logic                 is_data;
   logic                 prod0;
   logic                 prod1;
   logic                 last_ch;
   logic                 frame_tail;
   logic                 out_free;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      // effective geometry, with small/out-of-range settings clamped
      bb = (bb_cfg_ff < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : bb_cfg_ff;
      if (chn_cfg_ff == 4'd0) begin
         chn = CHN_CNT_W'(1);
      end else if (CHN_CNT_W'(chn_cfg_ff) > MAX_CHN) begin
         chn = MAX_CHN;
      end else begin
         chn = CHN_CNT_W'(chn_cfg_ff);
      end
      spb = {bb - 8'd2, 1'b0};

      // frame sample count is latched on the first byte of a frame
      if (bib_ff == 8'd0 && cc_ff == '0) begin
         fs_next = (sl_ff < 32'(spb)) ? sl_ff[IDX_W-1:0] : spb;
      end else begin
         fs_next = fs_ff;
      end

      is_data    = (bib_ff > 8'd1);
      idx0       = {bib_ff - 8'd2, 1'b0};
      idx1       = {bib_ff - 8'd2, 1'b1};
      prod0      = is_data && (idx0 < fs_ff);
      prod1      = is_data && (idx1 < fs_ff);
      last_ch    = (CHN_CNT_W'(cc_ff) + CHN_CNT_W'(1)) == chn;
      frame_tail = (32'(fs_ff) == sl_ff) && last_ch;
   end

   always_comb begin
      coef1_in   = coef1_ff;
      coef2_in   = coef2_ff;
      bb_cfg_in  = bb_cfg_ff;
      chn_cfg_in = chn_cfg_ff;
      total_in   = total_ff;
      cc_in      = cc_ff;
      bib_in     = bib_ff;
      scale_in   = scale_ff;
      sl_in      = sl_ff;
      fs_in      = fs_ff;
      state_in   = state_ff;
      op_in      = op_ff;
      nib_in     = nib_ff;
      h1_in      = h1_ff;
      h2_in      = h2_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_ch_in     = rsp_ch_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_fin_in    = rsp_fin_ff;

      hist_cmd  = '0;
      hist_addr = op_ff.ch;
      mac_ctl   = '0;

      unique case (state_ff)
         S_IDLE: begin
            hist_addr = cc_ff;
            if (accept) begin
               fs_in = fs_next;
               if (bib_ff == 8'd0) begin
                  scale_in = {req.data_byte, 8'h00};
               end else if (bib_ff == 8'd1) begin
                  scale_in = {scale_ff[15:8], req.data_byte};
               end

               // advance block / channel / frame position
               if (9'(bib_ff) + 9'd1 >= 9'(bb)) begin
                  bib_in = 8'd0;
                  if (CHN_CNT_W'(cc_ff) + CHN_CNT_W'(1) >= chn) begin
                     cc_in = '0;
                     sl_in = (32'(fs_next) > sl_ff) ? 32'd0 : sl_ff - 32'(fs_next);
                  end else begin
                     cc_in = cc_ff + CH_W'(1);
                  end
               end else begin
                  bib_in = bib_ff + 8'd1;
               end

               if (req.stream_end) begin
                  cc_in    = '0;
                  bib_in   = 8'd0;
                  scale_in = 16'd0;
                  sl_in    = total_ff;
                  fs_in    = '0;
               end

               op_in.ch      = cc_ff;
               op_in.scale   = scale_ff;
               op_in.data    = req.data_byte;
               op_in.base    = idx0;
               op_in.prod1   = prod1;
               op_in.fin0    = frame_tail && (10'(idx0) + 10'd1 == 10'(fs_ff));
               op_in.fin1    = frame_tail && (10'(idx1) + 10'd1 == 10'(fs_ff));
               op_in.restart = req.stream_end;
               nib_in        = 1'b0;

               if (prod0) begin
                  hist_cmd.rd_en = 1'b1;
                  state_in       = S_LOAD;
               end else if (req.stream_end) begin
                  hist_cmd.clear = 1'b1;
               end
            end
         end

         S_LOAD: begin
            h1_in    = hist_rdata[HIST_W-1:SAMPLE_W];
            h2_in    = hist_rdata[SAMPLE_W-1:0];
            state_in = S_MUL;
         end

         S_MUL: begin
            mac_ctl.mul_en = 1'b1;
            state_in       = S_SUM;
         end

         S_SUM: begin
            mac_ctl.sum_en = 1'b1;
            state_in       = S_EMIT;
         end

         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = mac_sample;
               rsp_ch_in     = 3'(op_ff.ch);
               rsp_idx_in    = nib_ff ? (op_ff.base | IDX_W'(1)) : op_ff.base;
               rsp_last_in   = nib_ff || !op_ff.prod1;
               rsp_fin_in    = nib_ff ? op_ff.fin1 : op_ff.fin0;
               h2_in         = h1_ff;
               h1_in         = mac_sample;
               if (!nib_ff && op_ff.prod1) begin
                  nib_in   = 1'b1;
                  state_in = S_MUL;
               end else begin
                  state_in = S_WRITE;
               end
            end
         end

         S_WRITE: begin
            // a stream end wipes every channel, so the write-back is moot
            if (op_ff.restart) begin
               hist_cmd.clear = 1'b1;
            end else begin
               hist_cmd.wr_en = 1'b1;
            end
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_FIRST:    coef1_in   = csr_wdata[SAMPLE_W-1:0];
            CSR_COEF_SECOND:   coef2_in   = csr_wdata[SAMPLE_W-1:0];
            CSR_BLOCK_BYTES:   bb_cfg_in  = csr_wdata[7:0];
            CSR_CHANNELS_USED: chn_cfg_in = csr_wdata[3:0];
            CSR_TOTAL_SAMPLES: begin
               total_in = csr_wdata;
               sl_in    = csr_wdata;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef1_ff     <= '0;
         coef2_ff     <= '0;
         bb_cfg_ff    <= RESET_BLOCK_BYTES;
         chn_cfg_ff   <= RESET_CHANNELS;
         total_ff     <= '1;
         cc_ff        <= '0;
         bib_ff       <= '0;
         scale_ff     <= '0;
         sl_ff        <= '1;
         fs_ff        <= '0;
         state_ff     <= S_IDLE;
         nib_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef1_ff     <= coef1_in;
         coef2_ff     <= coef2_in;
         bb_cfg_ff    <= bb_cfg_in;
         chn_cfg_ff   <= chn_cfg_in;
         total_ff     <= total_in;
         cc_ff        <= cc_in;
         bib_ff       <= bib_in;
         scale_ff     <= scale_in;
         sl_ff        <= sl_in;
         fs_ff        <= fs_in;
         state_ff     <= state_in;
         nib_ff       <= nib_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      h1_ff         <= h1_in;
      h2_ff         <= h2_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_ch_ff     <= rsp_ch_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   adx_hist #(.DEPTH(MAX_CHANNELS), .AW(CH_W)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .cmd     (hist_cmd),
      .addr    (hist_addr),
      .wr_data ({h1_ff, h2_ff}),
      .rd_data (hist_rdata)
   );

   adx_mac u_mac (
      .clock       (clock),
      .ctl         (mac_ctl),
      .coef_first  (coef1_ff),
      .coef_second (coef2_ff),
      .hist_newest (h1_ff),
      .hist_older  (h2_ff),
      .scale       (op_ff.scale),
      .nibble      (nib_ff ? op_ff.data[3:0] : op_ff.data[7:4]),
      .sample      (mac_sample)
   );

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sample       = rsp_sample_ff;
   assign rsp.channel      = rsp_ch_ff;
   assign rsp.sample_index = rsp_idx_ff;
   assign rsp.last_of_run  = rsp_last_ff;
   assign rsp.final_sample = rsp_fin_ff;

   // the stream's final sample closes its byte's run
   a_final_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.final_sample |-> rsp.last_of_run)
      else $error("final sample without last_of_run");

   // index never exceeds the largest block
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.sample_index < IDX_W'(506))
      else $error("sample index out of range");

   // history read and write-back never share a cycle
   a_hist_ports: assert property (@(posedge clock) disable iff (reset)
      !(hist_cmd.rd_en && (hist_cmd.wr_en || hist_cmd.clear)))
      else $error("history read collides with write");

   // a sample-producing byte holds off the next request
   a_busy_after_read: assert property (@(posedge clock) disable iff (reset)
      hist_cmd.rd_en |=> !req.ready)
      else $error("request taken while a byte is in flight");

endmodule
